### hdl/u128alu_pkg.sv
// package for the 128-bit unsigned alu: opcodes, status codes, widths
// no dependencies

package u128alu_pkg;

    localparam int HALF_W   = 64;
    localparam int LIMB_W   = 32;
    localparam int NUM_LIMB = 4;
    localparam int OP_W     = 3;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_INC  = 3'd3,
        OP_DEC  = 3'd4,
        OP_CMP  = 3'd5,
        OP_NAR  = 3'd6,
        OP_NONE = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    localparam logic [1:0] ORD_LESS = 2'd0;
    localparam logic [1:0] ORD_EQ   = 2'd1;
    localparam logic [1:0] ORD_GT   = 2'd2;

    // data handed from one cell to the next
    typedef struct packed {
        logic          valid;
        op_t           op;
        logic [127:0]  a;
        logic [127:0]  b;
        logic [127:0]  acc;
        logic          carry;
        logic          ovf;
        logic          a_nz;
        logic          b_nz;
        logic [1:0]    order;
    } cell_bus_t;

endpackage

### hdl/u128alu_cell.sv
// one alu chain cell: handles one 32-bit limb, or for multiply one partial row
// depends on u128alu_pkg

module u128alu_cell
    import u128alu_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  cell_bus_t in_bus,
    output cell_bus_t out_bus
);

    localparam int LO = IDX * LIMB_W;

    cell_bus_t            bus_next;
    cell_bus_t            bus_reg;
    logic                 valid_reg;
    logic [LIMB_W-1:0]    a_l;
    logic [LIMB_W-1:0]    b_l;
    logic [LIMB_W:0]      sum;
    logic [255:0]         prod_row;
    logic [255:0]         acc_ext;
    logic [256:0]         acc_sum;
    logic [LIMB_W-1:0]    b_limb;
    logic [2*LIMB_W-1:0]  pp [NUM_LIMB];

    assign a_l    = in_bus.a[LO +: LIMB_W];
    assign b_l    = in_bus.b[LO +: LIMB_W];
    assign b_limb = in_bus.b[LO +: LIMB_W];

    always_comb
    begin
        bus_next   = in_bus;
        sum        = '0;
        pp         = '{default: '0};
        prod_row   = '0;
        acc_ext    = '0;
        acc_sum    = '0;
        unique case (in_bus.op) inside
            OP_ADD:
            begin
                sum = {1'b0, a_l} + {1'b0, b_l} + {{LIMB_W{1'b0}}, in_bus.carry};
                bus_next.acc[LO +: LIMB_W] = sum[LIMB_W-1:0];
                bus_next.carry = sum[LIMB_W];
            end
            OP_SUB, OP_DEC:
            begin
                // borrow travels in carry
                sum = {1'b0, a_l} - {1'b0, (in_bus.op == OP_SUB) ? b_l : {LIMB_W{1'b0}}}
                      - {{LIMB_W{1'b0}}, in_bus.carry};
                bus_next.acc[LO +: LIMB_W] = sum[LIMB_W-1:0];
                bus_next.carry = sum[LIMB_W];
            end
            OP_INC:
            begin
                sum = {1'b0, a_l} + {{LIMB_W{1'b0}}, in_bus.carry};
                bus_next.acc[LO +: LIMB_W] = sum[LIMB_W-1:0];
                bus_next.carry = sum[LIMB_W];
            end
            OP_MUL:
            begin
                // acc is the low 128 bits; ovf collects bits beyond
                // the row is four 32x32 partial products of a against this b limb
                for (int j = 0; j < NUM_LIMB; j++)
                begin
                    pp[j]    = 64'(in_bus.a[j*LIMB_W +: LIMB_W]) * 64'(b_limb);
                    prod_row = prod_row + (256'(pp[j]) << (LO + j*LIMB_W));
                end
                acc_ext  = {128'd0, in_bus.acc};
                acc_sum  = {1'b0, acc_ext} + {1'b0, prod_row};
                bus_next.acc = acc_sum[127:0];
                bus_next.ovf = in_bus.ovf | (|acc_sum[256:128]);
            end
            OP_CMP:
            begin
                // upper limbs decide later, so later cells override
                if (a_l != b_l)
                begin
                    bus_next.order = (a_l < b_l) ? ORD_LESS : ORD_GT;
                end
            end
            default:
            begin
                bus_next.acc[LO +: LIMB_W] = a_l;
            end
        endcase
        bus_next.a_nz = in_bus.a_nz | (|a_l);
        bus_next.b_nz = in_bus.b_nz | (|b_l);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_bus.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bus_reg <= bus_next;
        end
    end

    always_comb
    begin
        out_bus       = bus_reg;
        out_bus.valid = valid_reg;
    end

endmodule

### hdl/unsigned_128bit_alu_top.sv
// top level of the 128-bit unsigned alu: a chain of four limb cells
// depends on u128alu_pkg and u128alu_cell
//
// channel | dir | tdata fields (low bit first)                  | tuser
// s_axis  | in  | a_high[63:0] a_low b_high b_low (256 bits)    | op[2:0]
// m_axis  | out | res_high[63:0] res_low order[1:0] status[1:0] | none
//
// a request walks the four cells, limb 0 first, one cell per cycle unless the output stalls
// results pass four cell registers and the output register; one request per cycle unless stalled
// the chain is a stalling pipeline: it advances when the output is free
// rst_n clears the valid bits only; datapath registers hold no reset
// multiply: each cell adds one 128x32 partial row into the running sum

module unsigned_128bit_alu_top
    import u128alu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [255:0] s_axis_tdata,   // a_high, a_low, b_high, b_low
    input  logic [2:0]   s_axis_tuser,   // op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata    // res_high, res_low, order, status, pad
);

    cell_bus_t      chain [NUM_LIMB+1];
    cell_bus_t      last;
    logic           en;
    logic           out_valid_reg;
    logic [135:0]   out_data_reg;
    logic [135:0]   out_data_next;
    status_t        st;
    logic [127:0]   res;
    logic [1:0]     ord;

    // the output register frees up when taken or empty
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_comb
    begin
        chain[0]       = '0;
        chain[0].valid = s_axis_tvalid;
        chain[0].op    = op_t'(s_axis_tuser);
        chain[0].a     = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
        chain[0].b     = {s_axis_tdata[191:128], s_axis_tdata[255:192]};
        chain[0].order = ORD_EQ;
        // increment and decrement start with the carry or borrow set
        chain[0].carry = (op_t'(s_axis_tuser) == OP_INC) || (op_t'(s_axis_tuser) == OP_DEC);
    end

    genvar g;
    generate
        for (g = 0; g < NUM_LIMB; g++)
        begin : g_cell
            u128alu_cell #(.IDX(g)) u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .in_bus  (chain[g]),
                .out_bus (chain[g+1])
            );
        end
    endgenerate

    assign last = chain[NUM_LIMB];

    always_comb
    begin
        st  = ST_OK;
        res = last.acc;
        ord = ORD_EQ;
        case (last.op)
            OP_ADD, OP_INC: st = last.carry ? ST_OVER : ST_OK;
            OP_SUB, OP_DEC: st = last.carry ? ST_UNDER : ST_OK;
            OP_MUL:         st = last.ovf ? ST_OVER : ST_OK;
            OP_CMP:
            begin
                res = '0;
                ord = last.order;
            end
            OP_NAR:
            begin
                res = {64'd0, last.a[63:0]};
                st  = (|last.a[127:64]) ? ST_OVER : ST_OK;
            end
            default: res = '0;
        endcase
        out_data_next = {4'd0, st, ord, res[63:0], res[127:64]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // a stalled result must not change
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed under stall");

    // order is equal for every op but compare, so a non-equal order must come with zero result data
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[129:128] != ORD_EQ
        |-> m_axis_tdata[127:0] == 128'd0)
        else $error("compare result carries data");

    // status code three never appears
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[131:130] != ST_RSVD)
        else $error("bad status code");

endmodule
